// ===== rtl/prd_pkg.sv =====
// shared widths, register indexes, side-band struct and helper function
// for the pinhole ray direction pipeline; no dependencies
package prd_pkg;

    localparam int PT_W     = 20;   // Q8.12 point and plane distance
    localparam int COMP_W   = 16;   // Q1.14 basis and output components
    localparam int BASIS_W  = 48;
    localparam int PROD_W   = 36;
    localparam int SUMC_W   = 37;
    localparam int MAG_W    = 36;
    localparam int NRM_W    = 30;   // scaled magnitudes, msb of max at bit 29
    localparam int POS_W    = 6;
    localparam int SQ_W     = 60;
    localparam int SUM_W    = 62;
    localparam int ROOT_W   = 64;
    localparam int LEN_W    = 31;
    localparam int FRAC_W   = 14;
    localparam int NUM_W    = 45;
    localparam int Q_W      = 15;
    localparam int IDX_W    = 2;

    localparam int SQRT_STAGES = 32;
    localparam int DIV_STAGES  = 15;
    localparam int NRM_TOP     = 29;

    localparam logic [PT_W-1:0] DIST_RESET = 20'd4096;

    typedef enum logic [IDX_W-1:0] {
        REG_BASIS_U = 2'd0,
        REG_BASIS_V = 2'd1,
        REG_BASIS_W = 2'd2,
        REG_DIST    = 2'd3
    } t_reg_idx;

    // side-band that travels with the square root
    typedef struct packed {
        logic [2:0][NRM_W-1:0] mag;
        logic [2:0]            neg;
        logic                  zero;
    } t_side;

    // position of the highest set bit, 0 when no bit is set
    function automatic logic [POS_W-1:0] lead_pos(input logic [MAG_W-1:0] v);
        logic [POS_W-1:0] p;
        p = '0;
        for (int i = 0; i < MAG_W; i++) begin
            if (v[i]) begin
                p = POS_W'(i);
            end
        end
        return p;
    endfunction

endpackage

// ===== rtl/prd_isqrt.sv =====
// pipelined integer square root, one result bit per stage
// depends on prd_pkg
module prd_isqrt (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [prd_pkg::SUM_W-1:0]    i_sum,
    input  prd_pkg::t_side               i_side,
    output logic                         o_valid,
    output logic [prd_pkg::LEN_W-1:0]    o_len,
    output prd_pkg::t_side               o_side
);

    localparam int N = prd_pkg::SQRT_STAGES;

    logic [prd_pkg::ROOT_W-1:0] r_n   [N];
    logic [prd_pkg::ROOT_W-1:0] r_res [N];
    prd_pkg::t_side             r_side[N];
    logic [N-1:0]               r_v;

    for (genvar j = 0; j < N; j++) begin : g_stage
        localparam logic [prd_pkg::ROOT_W-1:0] BIT =
            prd_pkg::ROOT_W'(64'd1 << (62 - 2 * j));
        logic [prd_pkg::ROOT_W-1:0] n_cur;
        logic [prd_pkg::ROOT_W-1:0] res_cur;
        logic [prd_pkg::ROOT_W-1:0] trial;
        prd_pkg::t_side             side_cur;
        logic                       v_cur;

        if (j == 0) begin : g_first
            assign n_cur    = prd_pkg::ROOT_W'(i_sum);
            assign res_cur  = '0;
            assign side_cur = i_side;
            assign v_cur    = i_valid;
        end else begin : g_next
            assign n_cur    = r_n[j-1];
            assign res_cur  = r_res[j-1];
            assign side_cur = r_side[j-1];
            assign v_cur    = r_v[j-1];
        end

        assign trial = res_cur + BIT;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (i_en) begin
                r_v[j] <= v_cur;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (n_cur >= trial) begin
                    r_n[j]   <= n_cur - trial;
                    r_res[j] <= (res_cur >> 1) + BIT;
                end else begin
                    r_n[j]   <= n_cur;
                    r_res[j] <= res_cur >> 1;
                end
                r_side[j] <= side_cur;
            end
        end
    end

    assign o_valid = r_v[N-1];
    assign o_len   = r_res[N-1][prd_pkg::LEN_W-1:0];
    assign o_side  = r_side[N-1];

endmodule

// ===== rtl/prd_div.sv =====
// pipelined restoring divider, three lanes sharing one divisor,
// one quotient bit per stage; depends on prd_pkg
module prd_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_valid,
    input  logic [prd_pkg::LEN_W-1:0]          i_len,
    input  prd_pkg::t_side                     i_side,
    output logic                               o_valid,
    output logic [2:0][prd_pkg::Q_W-1:0]       o_quo,
    output logic [2:0]                         o_neg,
    output logic                               o_zero
);

    localparam int N = prd_pkg::DIV_STAGES;

    // entry stage: numerator = mag * 2^14 + len / 2
    logic [2:0][prd_pkg::NUM_W-1:0] r0_rem;
    logic [prd_pkg::LEN_W-1:0]      r0_len;
    logic [2:0]                     r0_neg;
    logic                           r0_zero;
    logic                           r0_v;

    logic [2:0][prd_pkg::NUM_W-1:0] r_rem [N];
    logic [2:0][prd_pkg::Q_W-1:0]   r_quo [N];
    logic [prd_pkg::LEN_W-1:0]      r_len [N];
    logic [2:0]                     r_neg [N];
    logic [N-1:0]                   r_zero;
    logic [N-1:0]                   r_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
        end else if (i_en) begin
            r0_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r0_rem[k] <= {1'b0, i_side.mag[k], {prd_pkg::FRAC_W{1'b0}}}
                           + prd_pkg::NUM_W'(i_len >> 1);
            end
            r0_len  <= i_len;
            r0_neg  <= i_side.neg;
            r0_zero <= i_side.zero;
        end
    end

    for (genvar j = 0; j < N; j++) begin : g_stage
        localparam int SH = N - 1 - j;
        logic [2:0][prd_pkg::NUM_W-1:0] rem_cur;
        logic [2:0][prd_pkg::Q_W-1:0]   quo_cur;
        logic [prd_pkg::LEN_W-1:0]      len_cur;
        logic [2:0]                     neg_cur;
        logic                           zero_cur;
        logic                           v_cur;
        logic [prd_pkg::NUM_W-1:0]      dsr;

        if (j == 0) begin : g_first
            assign rem_cur  = r0_rem;
            assign quo_cur  = '0;
            assign len_cur  = r0_len;
            assign neg_cur  = r0_neg;
            assign zero_cur = r0_zero;
            assign v_cur    = r0_v;
        end else begin : g_next
            assign rem_cur  = r_rem[j-1];
            assign quo_cur  = r_quo[j-1];
            assign len_cur  = r_len[j-1];
            assign neg_cur  = r_neg[j-1];
            assign zero_cur = r_zero[j-1];
            assign v_cur    = r_v[j-1];
        end

        assign dsr = prd_pkg::NUM_W'(len_cur) << SH;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (i_en) begin
                r_v[j] <= v_cur;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int k = 0; k < 3; k++) begin
                    if (rem_cur[k] >= dsr) begin
                        r_rem[j][k]     <= rem_cur[k] - dsr;
                        r_quo[j][k]     <= quo_cur[k] | prd_pkg::Q_W'(1 << SH);
                    end else begin
                        r_rem[j][k]     <= rem_cur[k];
                        r_quo[j][k]     <= quo_cur[k];
                    end
                end
                r_len[j]  <= len_cur;
                r_neg[j]  <= neg_cur;
                r_zero[j] <= zero_cur;
            end
        end
    end

    assign o_valid = r_v[N-1];
    assign o_quo   = r_quo[N-1];
    assign o_neg   = r_neg[N-1];
    assign o_zero  = r_zero[N-1];

endmodule

// ===== rtl/pinhole_ray_direction.sv =====
// pinhole camera primary-ray direction: D = x*U + y*V - d*W, normalized
// accepts one item per cycle while the output is not stalled
// the whole pipeline advances together; it holds while the output waits
// synchronous active-low reset clears all valid bits and loads the basis
// registers with zero and the plane distance with 1.0; depends on prd_pkg,
// prd_isqrt and prd_div
module pinhole_ray_direction (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration writes
    input  logic                              i_cfg_we,
    input  logic [prd_pkg::IDX_W-1:0]         i_cfg_idx,
    input  logic [prd_pkg::BASIS_W-1:0]       i_cfg_data,
    // input channel
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [prd_pkg::PT_W-1:0]   i_point_x,
    input  logic signed [prd_pkg::PT_W-1:0]   i_point_y,
    // output channel
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [prd_pkg::COMP_W-1:0] o_dir_x,
    output logic signed [prd_pkg::COMP_W-1:0] o_dir_y,
    output logic signed [prd_pkg::COMP_W-1:0] o_dir_z,
    output logic                              o_zero_length
);

    localparam int PROD_W = prd_pkg::PROD_W;
    localparam int SUMC_W = prd_pkg::SUMC_W;
    localparam int MAG_W  = prd_pkg::MAG_W;
    localparam int NRM_W  = prd_pkg::NRM_W;
    localparam int POS_W  = prd_pkg::POS_W;

    // configuration registers
    logic [prd_pkg::BASIS_W-1:0] r_basis_u;
    logic [prd_pkg::BASIS_W-1:0] r_basis_v;
    logic [prd_pkg::BASIS_W-1:0] r_basis_w;
    logic [prd_pkg::PT_W-1:0]    r_dist;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_basis_u <= '0;
            r_basis_v <= '0;
            r_basis_w <= '0;
            r_dist    <= prd_pkg::DIST_RESET;
        end else if (i_cfg_we) begin
            unique case (prd_pkg::t_reg_idx'(i_cfg_idx))
                prd_pkg::REG_BASIS_U: r_basis_u <= i_cfg_data;
                prd_pkg::REG_BASIS_V: r_basis_v <= i_cfg_data;
                prd_pkg::REG_BASIS_W: r_basis_w <= i_cfg_data;
                prd_pkg::REG_DIST:    r_dist    <= i_cfg_data[prd_pkg::PT_W-1:0];
                default: ;
            endcase
        end
    end

    // global advance: move whenever the output register is free or taken
    logic en;
    logic r_vout;
    assign en      = ~r_vout | i_ready;
    assign o_ready = en;

    // stage valid bits for stages 1..7
    logic [7:1] r_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[6:1], i_valid};
        end
    end

    // stage 1: nine products
    logic signed [PROD_W-1:0] r1_pu [3];
    logic signed [PROD_W-1:0] r1_pv [3];
    logic signed [PROD_W-1:0] r1_pw [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r1_pu[k] <= PROD_W'(i_point_x * $signed(r_basis_u[16*k +: 16]));
                r1_pv[k] <= PROD_W'(i_point_y * $signed(r_basis_v[16*k +: 16]));
                r1_pw[k] <= PROD_W'($signed({1'b0, r_dist})
                                    * $signed(r_basis_w[16*k +: 16]));
            end
        end
    end

    // stage 2: component sums, split into sign and magnitude
    logic [MAG_W-1:0] r2_mag [3];
    logic [2:0]       r2_neg;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                logic signed [SUMC_W-1:0] c;
                logic signed [SUMC_W-1:0] a;
                c = SUMC_W'(r1_pu[k]) + SUMC_W'(r1_pv[k]) - SUMC_W'(r1_pw[k]);
                a = c[SUMC_W-1] ? -c : c;
                r2_neg[k] <= c[SUMC_W-1];
                r2_mag[k] <= a[MAG_W-1:0];
            end
        end
    end

    // stage 3: largest magnitude
    logic [MAG_W-1:0] r3_mag [3];
    logic [2:0]       r3_neg;
    logic [MAG_W-1:0] r3_mx;
    logic [MAG_W-1:0] mx01;

    assign mx01 = (r2_mag[0] > r2_mag[1]) ? r2_mag[0] : r2_mag[1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_mag <= r2_mag;
            r3_neg <= r2_neg;
            r3_mx  <= (mx01 > r2_mag[2]) ? mx01 : r2_mag[2];
        end
    end

    // stage 4: leading-one position of the largest magnitude
    logic [MAG_W-1:0] r4_mag [3];
    logic [2:0]       r4_neg;
    logic [POS_W-1:0] r4_pos;
    logic             r4_zero;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_mag  <= r3_mag;
            r4_neg  <= r3_neg;
            r4_pos  <= prd_pkg::lead_pos(r3_mx);
            r4_zero <= (r3_mx == '0);
        end
    end

    // stage 5: block scaling, msb of the largest lands on bit 29
    logic [NRM_W-1:0] r5_mag [3];
    logic [2:0]       r5_neg;
    logic             r5_zero;
    logic             shr;
    logic [POS_W-1:0] rsh;
    logic [POS_W-1:0] lsh;

    assign shr = (r4_pos >= POS_W'(prd_pkg::NRM_TOP));
    assign rsh = r4_pos - POS_W'(prd_pkg::NRM_TOP);
    assign lsh = POS_W'(prd_pkg::NRM_TOP) - r4_pos;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                logic [MAG_W-1:0] m;
                m = shr ? (r4_mag[k] >> rsh) : (r4_mag[k] << lsh);
                r5_mag[k] <= m[NRM_W-1:0];
            end
            r5_neg  <= r4_neg;
            r5_zero <= r4_zero;
        end
    end

    // stage 6: squares
    logic [prd_pkg::SQ_W-1:0] r6_sq [3];
    prd_pkg::t_side           r6_side;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r6_sq[k]          <= prd_pkg::SQ_W'(r5_mag[k]) * prd_pkg::SQ_W'(r5_mag[k]);
                r6_side.mag[k]    <= r5_mag[k];
            end
            r6_side.neg  <= r5_neg;
            r6_side.zero <= r5_zero;
        end
    end

    // stage 7: sum of squares
    logic [prd_pkg::SUM_W-1:0] r7_sum;
    prd_pkg::t_side            r7_side;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_sum  <= prd_pkg::SUM_W'(r6_sq[0]) + prd_pkg::SUM_W'(r6_sq[1])
                     + prd_pkg::SUM_W'(r6_sq[2]);
            r7_side <= r6_side;
        end
    end

    // length: 32-stage square root
    logic                      sq_valid;
    logic [prd_pkg::LEN_W-1:0] sq_len;
    prd_pkg::t_side            sq_side;

    prd_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_v[7]),
        .i_sum   (r7_sum),
        .i_side  (r7_side),
        .o_valid (sq_valid),
        .o_len   (sq_len),
        .o_side  (sq_side)
    );

    // rounded quotients: 16-stage divider
    logic                            dv_valid;
    logic [2:0][prd_pkg::Q_W-1:0]    dv_quo;
    logic [2:0]                      dv_neg;
    logic                            dv_zero;

    prd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sq_valid),
        .i_len   (sq_len),
        .i_side  (sq_side),
        .o_valid (dv_valid),
        .o_quo   (dv_quo),
        .o_neg   (dv_neg),
        .o_zero  (dv_zero)
    );

    // output register: apply sign, zero vector forces zeros
    logic signed [prd_pkg::COMP_W-1:0] r_dir [3];
    logic                              r_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vout <= 1'b0;
        end else if (en) begin
            r_vout <= dv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                logic [prd_pkg::COMP_W-1:0] q;
                q = prd_pkg::COMP_W'(dv_quo[k]);
                if (dv_zero) begin
                    r_dir[k] <= '0;
                end else begin
                    r_dir[k] <= dv_neg[k] ? -q : q;
                end
            end
            r_zero <= dv_zero;
        end
    end

    assign o_valid       = r_vout;
    assign o_dir_x       = r_dir[0];
    assign o_dir_y       = r_dir[1];
    assign o_dir_z       = r_dir[2];
    assign o_zero_length = r_zero;

endmodule
